/* hw/rtl/ntc_pkg.sv */
// shared types and constants for the ntc trimmed-mean thermometer
`timescale 1ns / 1ps
package ntc_pkg;

    localparam int WINDOW = 32;
    localparam int TRIM_REQ = 6;
    localparam int TRIM = (TRIM_REQ > (WINDOW - 1) / 2) ? (WINDOW - 1) / 2 : TRIM_REQ;
    localparam int KEPT = WINDOW - 2 * TRIM;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = 12 + $clog2(WINDOW + 1);

    // mean = (sum * MEAN_RECIP) >> MEAN_SH, exact for every SUM_W-bit sum
    localparam int MEAN_SH = SUM_W + $clog2(KEPT);
    localparam logic [39:0] MEAN_RECIP =
        40'(((64'd1 << MEAN_SH) + 64'(KEPT) - 64'd1) / 64'(KEPT));

    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic [63:0] ZERO_C_Q16 = 64'd17901158;
    localparam logic signed [39:0] ALPHA_Q16 = 40'sd5243;

    localparam logic [2:0] REG_DIVIDER = 3'd0;
    localparam logic [2:0] REG_NOMINAL = 3'd1;
    localparam logic [2:0] REG_BETA = 3'd2;
    localparam logic [2:0] REG_REFK = 3'd3;
    localparam logic [2:0] REG_AFLOOR = 3'd4;
    localparam logic [2:0] REG_ACEIL = 3'd5;
    localparam logic [2:0] REG_TFLOOR = 3'd6;
    localparam logic [2:0] REG_TCEIL = 3'd7;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ADC = 2'd1;
    localparam logic [1:0] ST_TEMP = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_INS, S_SUM, S_DIV, S_CHK,
        S_LOGSET, S_LOGRUN, S_LOGNEXT, S_LNMUL,
        S_DIVSET, S_DIVRUN, S_DIVNEXT, S_TK,
        S_TCONV, S_EMA, S_OUT
    } state_t;

    // one cell's control from the sequencer
    typedef struct packed {
        logic       insert;
        logic [11:0] key;
        logic       shift;
    } cell_ctl_t;

endpackage

/* hw/rtl/ntc_cell.sv */
// one window cell: holds one sorted sample and shifts toward its upper neighbor
`timescale 1ns / 1ps
module ntc_cell
    import ntc_pkg::*;
(
    input  logic        aclk,
    input  cell_ctl_t   ctl,
    input  logic        occupied,
    input  logic        pos_valid,
    input  logic [11:0] lower_val,
    input  logic        lower_gt,
    output logic [11:0] val,
    output logic        gt
);
    logic [11:0] val_reg;

    // cell value greater than key and occupied
    assign gt = occupied && (val_reg > ctl.key);
    assign val = val_reg;

    always_ff @(posedge aclk) begin
        if (ctl.insert && pos_valid) begin
            if (gt) begin
                // greater entries move up by one
                val_reg <= lower_gt ? lower_val : ctl.key;
            end else if (occupied == 1'b0 && !lower_gt) begin
                val_reg <= val_reg;
            end
        end else if (ctl.insert && !pos_valid) begin
            if (!lower_gt) val_reg <= ctl.key;
            else val_reg <= lower_val;
        end else if (ctl.shift) begin
            val_reg <= lower_val;
        end
    end
endmodule

/* hw/rtl/ntc_window.sv */
// row of sort cells with a rotating readout for the trimmed sum
`timescale 1ns / 1ps
module ntc_window
    import ntc_pkg::*;
(
    input  logic              aclk,
    input  cell_ctl_t         ctl,
    input  logic [CNT_W-1:0]  count,
    output logic [11:0]       head
);
    logic [11:0] vals [WINDOW];
    logic        gts  [WINDOW];

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++) begin : g_cell
            logic [11:0] lv;
            logic        lg;
            if (i == 0) begin : g_first
                // rotation wraps the top cell into the bottom
                assign lv = ctl.shift ? vals[WINDOW-1] : 12'd0;
                assign lg = 1'b0;
            end else begin : g_rest
                assign lv = vals[i-1];
                assign lg = gts[i-1];
            end
            ntc_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .occupied (CNT_W'(i) < count),
                .pos_valid(CNT_W'(i) < count),
                .lower_val(lv),
                .lower_gt (lg),
                .val      (vals[i]),
                .gt       (gts[i])
            );
        end
    endgenerate

    assign head = vals[WINDOW-1];
endmodule

/* hw/rtl/ntc_trimmed_mean_temperature.sv */
// top level: window, trimmed mean, beta-equation temperature and filter
// ---------------------------------------------------------------------------
// usage: adc samples enter on s_valid/s_ready (s_adc_sample). each item is
// sorted into a row of 32 cells (insertion compares every cell to the new
// key at once; greater cells move up). the 32nd item of a window starts the
// computation: the row rotates once around to sum the middle 20 samples,
// the mean takes one reciprocal multiply, four log2 values run in turn on a
// shared squaring unit, and three 64-bit restoring divisions follow (the
// first two in one divider state, the third in its own). when the mean is
// out of range the log2 and division steps are skipped; the other 31 items
// of a window are only sorted in. the result is held on m_valid until
// m_ready; while the result waits or the computation runs s_ready is low.
// config registers are written through cfg_we/cfg_index/cfg_data at any
// clock while idle. reset (aresetn low, synchronous) restores the register
// defaults, empties the window and sets both temperatures to 25 degrees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_trimmed_mean_temperature
    import ntc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_adc_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [11:0]        m_adc_mean,
    output logic signed [16:0] m_raw_temp_q8,
    output logic signed [16:0] m_filtered_temp_q8,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data
);
    // configuration
    logic [19:0] div_ohms_reg, nom_ohms_reg;
    logic [13:0] beta_reg;
    logic [16:0] refk_reg;
    logic [11:0] afloor_reg, aceil_reg;
    logic signed [16:0] tfloor_reg, tceil_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_ohms_reg <= 20'd10000;
            nom_ohms_reg <= 20'd10000;
            beta_reg     <= 14'd3950;
            refk_reg     <= 17'd76326;
            afloor_reg   <= 12'd50;
            aceil_reg    <= 12'd4045;
            tfloor_reg   <= -17'sd10240;
            tceil_reg    <= 17'sd32000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DIVIDER: div_ohms_reg <= cfg_data;
                REG_NOMINAL: nom_ohms_reg <= cfg_data;
                REG_BETA:    beta_reg     <= cfg_data[13:0];
                REG_REFK:    refk_reg     <= cfg_data[16:0];
                REG_AFLOOR:  afloor_reg   <= cfg_data[11:0];
                REG_ACEIL:   aceil_reg    <= cfg_data[11:0];
                REG_TFLOOR:  tfloor_reg   <= cfg_data[16:0];
                REG_TCEIL:   tceil_reg    <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  lsel_reg, lsel_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [11:0] mean_reg, mean_next;
    logic [1:0]  status_reg, status_next;
    logic signed [16:0] raw_reg, raw_next, filt_reg, filt_next;
    logic seeded_reg, seeded_next;
    logic signed [31:0] lg_reg, lg_next;
    logic [20:0] la_reg, la_next;
    logic [31:0] ly_reg, ly_next;
    logic [23:0] lfrac_reg, lfrac_next;
    logic [4:0]  lk_reg, lk_next;
    logic [63:0] dn_reg, dn_next, dd_reg, dd_next, dq_reg, dq_next;
    logic [64:0] drem_reg, drem_next;
    logic        dsel_reg, dsel_next;
    logic signed [63:0] inv_reg, inv_next;
    logic [63:0] mag_reg, mag_next;
    logic signed [63:0] tc_reg, tc_next;
    logic        ok_reg, ok_next;
    logic signed [39:0] p_reg, p_next;

    cell_ctl_t ctl;
    logic [11:0] head;

    ntc_window u_window (
        .aclk (aclk),
        .ctl  (ctl),
        .count(count_reg),
        .head (head)
    );

    // helpers
    logic [19:0] div1, nom1;
    logic [13:0] beta1;
    logic [16:0] refk1;
    logic [4:0]  msb_pos;
    logic [63:0] ysq;
    logic [64:0] rsh;

    assign div1  = (div_ohms_reg == 20'd0) ? 20'd1 : div_ohms_reg;
    assign nom1  = (nom_ohms_reg == 20'd0) ? 20'd1 : nom_ohms_reg;
    assign beta1 = (beta_reg == 14'd0) ? 14'd1 : beta_reg;
    assign refk1 = (refk_reg == 17'd0) ? 17'd1 : refk_reg;

    always_comb begin
        msb_pos = 5'd0;
        for (int b = 0; b < 21; b++) begin
            if (la_reg[b]) msb_pos = 5'(b);
        end
    end
    assign ysq = 64'(ly_reg) * 64'(ly_reg);
    assign rsh = {drem_reg[63:0], dn_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            raw_reg    <= 17'sd6400;
            filt_reg   <= 17'sd6400;
            seeded_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            raw_reg    <= raw_next;
            filt_reg   <= filt_next;
            seeded_reg <= seeded_next;
        end
        step_reg <= step_next;  lsel_reg <= lsel_next;  sum_reg <= sum_next;
        mean_reg <= mean_next;  status_reg <= status_next; lg_reg <= lg_next;
        la_reg <= la_next;  ly_reg <= ly_next;  lfrac_reg <= lfrac_next;
        lk_reg <= lk_next;  dn_reg <= dn_next;  dd_reg <= dd_next;
        dq_reg <= dq_next;  drem_reg <= drem_next; dsel_reg <= dsel_next;
        inv_reg <= inv_next; mag_reg <= mag_next; tc_reg <= tc_next;
        ok_reg <= ok_next;  p_reg <= p_next;
    end

    always_comb begin
        logic signed [63:0] step;
        logic signed [17:0] fsum;
        logic [64:0] u;
        logic [39:0] mean_prod;
        state_next = state_reg;  count_next = count_reg; step_next = step_reg;
        lsel_next = lsel_reg;  sum_next = sum_reg;  mean_next = mean_reg;
        status_next = status_reg;  raw_next = raw_reg;  filt_next = filt_reg;
        seeded_next = seeded_reg;  lg_next = lg_reg;  la_next = la_reg;
        ly_next = ly_reg;  lfrac_next = lfrac_reg;  lk_next = lk_reg;
        dn_next = dn_reg;  dd_next = dd_reg;  dq_next = dq_reg;
        drem_next = drem_reg;  dsel_next = dsel_reg;  inv_next = inv_reg;
        mag_next = mag_reg;  tc_next = tc_reg;  ok_next = ok_reg;  p_next = p_reg;
        step = '0;  fsum = '0;  u = '0;  mean_prod = '0;
        ctl.insert = 1'b0;  ctl.shift = 1'b0;  ctl.key = s_adc_sample;
        s_ready = 1'b0;  m_valid = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.insert = 1'b1;
                    if (count_reg == CNT_W'(WINDOW - 1)) begin
                        count_next = CNT_W'(WINDOW);
                        state_next = S_SUM;
                        step_next = '0;
                        sum_next = '0;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_SUM: begin
                // rotate the row; the top cell passes position 31-step
                ctl.shift = 1'b1;
                if ((6'(WINDOW - 1) - step_reg) >= 6'(TRIM) &&
                    (6'(WINDOW - 1) - step_reg) < 6'(WINDOW - TRIM))
                    sum_next = sum_reg + SUM_W'(head);
                step_next = step_reg + 1'b1;
                if (step_reg == 6'(WINDOW - 1)) begin
                    state_next = S_DIV;
                    step_next = '0;
                end
            end
            S_DIV: begin
                // mean by reciprocal multiplication
                mean_prod = 40'(sum_reg) * MEAN_RECIP;
                dq_next = 64'(mean_prod >> MEAN_SH);
                state_next = S_CHK;
            end
            S_DIVRUN: begin
                // restoring divider, one quotient bit a cycle
                if (rsh >= {1'b0, dd_reg}) begin
                    drem_next = rsh - {1'b0, dd_reg};
                    dq_next = {dq_reg[62:0], 1'b1};
                end else begin
                    drem_next = rsh;
                    dq_next = {dq_reg[62:0], 1'b0};
                end
                dn_next = {dn_reg[62:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd63) begin
                    state_next = S_DIVNEXT;
                end
            end
            S_CHK: begin
                count_next = '0;
                mean_next = dq_reg[11:0];
                if (dq_reg[11:0] < afloor_reg || dq_reg[11:0] > aceil_reg ||
                    dq_reg[11:0] == 12'd0 || dq_reg[11:0] == 12'hFFF) begin
                    status_next = ST_ADC;
                    state_next = S_OUT;
                end else begin
                    lsel_next = 2'd0;
                    lg_next = '0;
                    state_next = S_LOGSET;
                end
            end
            S_LOGSET: begin
                unique case (lsel_reg)
                    2'd0: la_next = 21'(div1);
                    2'd1: la_next = 21'(12'hFFF - mean_reg);
                    2'd2: la_next = 21'(mean_reg);
                    default: la_next = 21'(nom1);
                endcase
                state_next = S_LOGRUN;
                step_next = 6'h3F;
                lfrac_next = '0;
            end
            S_LOGRUN: begin
                if (step_reg == 6'h3F) begin
                    lk_next = msb_pos;
                    ly_next = 32'({11'd0, la_reg} << (5'd30 - msb_pos));
                    step_next = '0;
                end else begin
                    if (ysq[61:30] >= 32'h8000_0000) begin
                        ly_next = ysq[62:31];
                        lfrac_next = {lfrac_reg[22:0], 1'b1};
                    end else begin
                        ly_next = ysq[61:30];
                        lfrac_next = {lfrac_reg[22:0], 1'b0};
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == 6'd23) state_next = S_LOGNEXT;
                end
            end
            S_LOGNEXT: begin
                if (lsel_reg[1] ^ lsel_reg[0])
                    lg_next = lg_reg + $signed({3'd0, lk_reg, lfrac_reg});
                else if (lsel_reg == 2'd0)
                    lg_next = lg_reg + $signed({3'd0, lk_reg, lfrac_reg});
                else
                    lg_next = lg_reg - $signed({3'd0, lk_reg, lfrac_reg});
                if (lsel_reg == 2'd2)
                    lg_next = lg_reg - $signed({3'd0, lk_reg, lfrac_reg});
                lsel_next = lsel_reg + 1'b1;
                state_next = (lsel_reg == 2'd3) ? S_LNMUL : S_LOGSET;
            end
            S_LNMUL: begin
                mag_next = 64'(lg_reg[31] ? -lg_reg : lg_reg) * LN2_Q30;
                state_next = S_DIVSET;
                dsel_next = 1'b0;
            end
            S_DIVSET: begin
                if (!dsel_reg) begin
                    dn_next = mag_reg;
                    dd_next = 64'(beta1) << 14;
                end else begin
                    dn_next = 64'h0001_0000_0000_0000;
                    dd_next = 64'(refk1);
                end
                drem_next = '0;  dq_next = '0;  step_next = '0;
                state_next = S_DIVRUN;
            end
            S_DIVNEXT: begin
                if (!dsel_reg) begin
                    inv_next = $signed(dq_reg);
                    dsel_next = 1'b1;
                    state_next = S_DIVSET;
                end else begin
                    inv_next = lg_reg[31] ? $signed(dq_reg) - inv_reg
                                          : $signed(dq_reg) + inv_reg;
                    state_next = S_TK;
                end
            end
            S_TK: begin
                if (inv_reg <= 0) begin
                    raw_next = -17'sd65536;
                    status_next = ST_TEMP;
                    state_next = S_OUT;
                end else begin
                    dn_next = 64'h0100_0000_0000_0000;
                    dd_next = inv_reg;
                    drem_next = '0;  dq_next = '0;  step_next = '0;
                    dsel_next = 1'b1;
                    state_next = S_TCONV;
                end
            end
            S_TCONV: begin
                if (step_reg[5] == 1'b0 || step_reg != 6'd63 || 1'b1) begin
                    if (rsh >= {1'b0, dd_reg}) begin
                        drem_next = rsh - {1'b0, dd_reg};
                        dq_next = {dq_reg[62:0], 1'b1};
                    end else begin
                        drem_next = rsh;
                        dq_next = {dq_reg[62:0], 1'b0};
                    end
                    dn_next = {dn_reg[62:0], 1'b0};
                    step_next = step_reg + 1'b1;
                end
                if (step_reg == 6'd63) begin
                    u = 65'(dq_next) + 65'(64'd33554560) - 65'(ZERO_C_Q16);
                    tc_next = $signed(64'(u[64:8])) - 64'sd131072;
                    state_next = S_EMA;
                    ok_next = 1'b0;
                end
            end
            S_EMA: begin
                if (tc_reg < -64'sd65536) raw_next = -17'sd65536;
                else if (tc_reg > 64'sd65535) raw_next = 17'sd65535;
                else raw_next = tc_reg[16:0];
                if (tc_reg < 64'(tfloor_reg) || tc_reg > 64'(tceil_reg)) begin
                    status_next = ST_TEMP;
                    state_next = S_OUT;
                end else if (!ok_reg) begin
                    status_next = ST_OK;
                    ok_next = 1'b1;
                    p_next = (40'(tc_reg[16:0] > 0 ? 0 : 0)) ;
                    if (!seeded_reg) begin
                        filt_next = raw_next;
                        seeded_next = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        p_next = 40'(40'(signed'(raw_next)) - 40'(filt_reg)) * ALPHA_Q16;
                    end
                end else begin
                    step = 64'((p_reg + 40'sd32768) >>> 16);
                    if (step > 64'sd64) step = 64'sd64;
                    if (step < -64'sd64) step = -64'sd64;
                    fsum = 18'(filt_reg) + 18'(step);
                    if (fsum < -18'sd65536) filt_next = -17'sd65536;
                    else if (fsum > 18'sd65535) filt_next = 17'sd65535;
                    else filt_next = fsum[16:0];
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_status = status_reg;
    assign m_adc_mean = mean_reg;
    assign m_raw_temp_q8 = raw_reg;
    assign m_filtered_temp_q8 = filt_reg;

    // a result is offered only after a full window
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> count_reg == '0)
        else $error("result without complete window");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while result pending");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_ADC || m_status == ST_TEMP))
        else $error("bad status");
endmodule

/* bench/tb_ntc_trimmed_mean_temperature.sv */
// self-checking bench for the ntc trimmed-mean thermometer
`timescale 1ns / 1ps
module tb_ntc_trimmed_mean_temperature
    import ntc_pkg::*;
();

    localparam int STALL_LIMIT = 4000;
    localparam int WINDOWS_PER_PHASE = 5;
    localparam int CALM_WINDOWS = 4;
    localparam int NUM_PHASES = 9;

    typedef struct {
        logic [1:0]         status;
        logic [11:0]        mean;
        logic signed [16:0] raw;
        logic signed [16:0] filt;
    } reading_t;

    class thermo_scoreboard;
        logic [19:0] divider, nominal;
        logic [13:0] beta;
        logic [16:0] refk;
        logic [11:0] adc_lo, adc_hi;
        logic signed [16:0] temp_lo, temp_hi;
        logic [11:0] window_q[$];
        longint raw_t, filt_t;
        bit seeded;
        reading_t readings[$];
        int errors;

        function new();
            divider = 10000; nominal = 10000; beta = 3950; refk = 76326;
            adc_lo = 50; adc_hi = 4045; temp_lo = -10240; temp_hi = 32000;
            raw_t = 6400; filt_t = 6400; seeded = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [19:0] d);
            case (idx)
                REG_DIVIDER: divider = d;
                REG_NOMINAL: nominal = d;
                REG_BETA:    beta = d[13:0];
                REG_REFK:    refk = d[16:0];
                REG_AFLOOR:  adc_lo = d[11:0];
                REG_ACEIL:   adc_hi = d[11:0];
                REG_TFLOOR:  temp_lo = d[16:0];
                REG_TCEIL:   temp_hi = d[16:0];
                default: ;
            endcase
        endfunction

        function longint log2_q24(longint unsigned a);
            int k;
            longint unsigned y, frac;
            k = 0;
            frac = 0;
            while (k < 40 && (a >> (k + 1)) != 0) k++;
            y = a << (30 - k);
            for (int i = 0; i < 24; i++) begin
                y = (y * y) >> 30;
                frac = frac << 1;
                if (y >= (64'd2 << 30)) begin
                    y = y >> 1;
                    frac = frac | 1;
                end
            end
            return longint'(k) * 16777216 + longint'(frac);
        endfunction

        function longint unsigned one_if_zero(longint unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        // returns 0 when the inverse temperature is not positive
        function bit beta_temp(int m, output longint t_c);
            longint lg, inv;
            longint unsigned mag, term, inv0, tk, u;
            lg = log2_q24(one_if_zero(divider)) + log2_q24(4095 - m)
               - log2_q24(m) - log2_q24(one_if_zero(nominal));
            mag = longint'(lg < 0 ? -lg : lg) * LN2_Q30;
            term = mag / (one_if_zero(beta) << 14);
            inv0 = (64'd1 << 48) / one_if_zero(refk);
            inv = (lg < 0) ? longint'(inv0) - longint'(term) : longint'(inv0) + longint'(term);
            t_c = 0;
            if (inv <= 0) return 0;
            tk = (64'd1 << 56) / longint'(inv);
            u = tk + (64'd1 << 25) + 128 - ZERO_C_Q16;
            t_c = longint'(u >> 8) - 131072;
            return 1;
        endfunction

        function longint sat17(longint v);
            if (v < -65536) return -65536;
            if (v > 65535) return 65535;
            return v;
        endfunction

        function void note_sample(logic [11:0] s);
            longint unsigned sum;
            longint t, p, step;
            int m;
            reading_t r;
            window_q.push_back(s);
            if (window_q.size() < WINDOW) return;
            window_q.sort();
            sum = 0;
            for (int j = TRIM; j < WINDOW - TRIM; j++) sum += window_q[j];
            window_q.delete();
            m = int'(sum / KEPT);
            if (m < adc_lo || m > adc_hi || m == 0 || m >= 4095) begin
                r.status = ST_ADC;
            end else if (!beta_temp(m, t)) begin
                raw_t = -65536;
                r.status = ST_TEMP;
            end else begin
                raw_t = sat17(t);
                if (t < longint'(temp_lo) || t > longint'(temp_hi)) begin
                    r.status = ST_TEMP;
                end else begin
                    r.status = ST_OK;
                    if (!seeded) begin
                        filt_t = raw_t;
                        seeded = 1;
                    end else begin
                        p = (raw_t - filt_t) * longint'(ALPHA_Q16);
                        step = (p + 32768) >>> 16;
                        if (step > 64) step = 64;
                        if (step < -64) step = -64;
                        filt_t = sat17(filt_t + step);
                    end
                end
            end
            r.mean = m[11:0];
            r.raw = raw_t[16:0];
            r.filt = filt_t[16:0];
            readings.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_reading(logic [1:0] st, logic [11:0] mean,
                           logic signed [16:0] raw, logic signed [16:0] filt);
            reading_t e;
            if (readings.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            e = readings.pop_front();
            if (st !== e.status) report($sformatf("status %0d want %0d", st, e.status));
            if (mean !== e.mean) report($sformatf("mean %0d want %0d", mean, e.mean));
            if (raw !== e.raw) report($sformatf("raw %0d want %0d", raw, e.raw));
            if (filt !== e.filt) report($sformatf("filtered %0d want %0d", filt, e.filt));
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready;
    logic [11:0] s_adc_sample = 0;
    logic m_valid, m_ready = 0;
    logic [1:0] m_status;
    logic [11:0] m_adc_mean;
    logic signed [16:0] m_raw_temp_q8, m_filtered_temp_q8;
    logic cfg_we = 0;
    logic [2:0] cfg_index = 0;
    logic [19:0] cfg_data = 0;

    thermo_scoreboard sb = new();
    bit calm = 0;
    int quiet_cycles = 0;
    int ready_hold = 0;

    ntc_trimmed_mean_temperature dut (.*);

    always #10 aclk = ~aclk;

    // receiver stalls in bursts
    always @(negedge aclk) begin
        if (calm) begin
            m_ready <= 1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready <= ~m_ready;
            ready_hold <= $urandom_range(1, 18);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_reading(m_status, m_adc_mean, m_raw_temp_q8, m_filtered_temp_q8);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("ntc_trimmed_mean_temperature regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task send(logic [11:0] v);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1;
        s_adc_sample <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(v);
    endtask

    task write_reg(logic [2:0] idx, logic [19:0] d);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        sb.set_reg(idx, d);
    endtask

    // stop sending, wait out pending readings and the last insert
    task drain();
        @(negedge aclk);
        s_valid <= 0;
        while (sb.readings.size() != 0) @(posedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task load_phase(int ph);
        logic [19:0] d[8];
        d = '{20'd10000, 20'd10000, 20'd3950, 20'd76326, 20'd50, 20'd4045,
              20'(-10240), 20'd32000};
        case (ph)
            1: d = '{20'($urandom_range(1000, 100000)), 20'($urandom_range(1000, 100000)),
                     20'($urandom_range(3000, 4500)), 20'($urandom_range(70000, 80000)),
                     20'($urandom_range(1, 300)), 20'($urandom_range(3800, 4095)),
                     20'(-65536), 20'd65535};
            2: d = '{20'd1, 20'd1, 20'd1000, 20'd256, 20'd1, 20'd4095,
                     20'(-65536), 20'd65535};
            3: d = '{20'd1000000, 20'd1000000, 20'd10000, 20'd131071, 20'd1, 20'd4095,
                     20'(-65536), 20'd65535};
            // zero resistor, beta and reference read as one
            4: d = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd4095,
                     20'(-65536), 20'd65535};
            // floors above ceilings
            5: d = '{20'd10000, 20'd10000, 20'd3950, 20'd76326, 20'd3000, 20'd1000,
                     20'd100, 20'(-100)};
            // tight plausible range around room temperature
            6: d = '{20'd10000, 20'd10000, 20'd3950, 20'd76326, 20'd50, 20'd4045,
                     20'd5000, 20'd8000};
            // large log term drives the inverse temperature negative
            7: d = '{20'd1, 20'd1000000, 20'd1000, 20'd76326, 20'd1, 20'd4095,
                     20'(-65536), 20'd65535};
            8: for (int i = 0; i < 8; i++) d[i] = 20'($urandom_range(0, 20'hFFFFF));
            default: ;
        endcase
        for (int i = 0; i < 8; i++) write_reg(i[2:0], d[i]);
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task send_window();
        int kind, center, spread, v;
        kind = $urandom_range(0, 19);
        center = $urandom_range(0, 4095);
        spread = $urandom_range(0, 200);
        if (kind < 2) center = (kind == 0) ? sb.adc_lo : sb.adc_hi;
        for (int i = 0; i < WINDOW; i++) begin
            if (kind < 2) begin
                v = center;
            end else if (kind < 5 || $urandom_range(0, 9) == 0) begin
                v = $urandom_range(0, 4095);
            end else begin
                v = center + $urandom_range(0, 2 * spread) - spread;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
            end
            send(v[11:0]);
        end
    endtask

    initial begin
        int n_windows;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: extremes and walking ones, then a steady mid-scale window and a full-scale one
        send(12'd0);
        send(12'hFFF);
        for (int b = 0; b < 12; b++) send(12'd1 << b);
        send(12'hAAA);
        send(12'h555);
        for (int i = 0; i < WINDOW - 16; i++) send(12'($urandom_range(0, 4095)));
        for (int i = 0; i < WINDOW; i++) send(12'd2048);
        for (int i = 0; i < WINDOW; i++) send(12'd4095);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_phase(ph);
            n_windows = WINDOWS_PER_PHASE;
            if (ph == NUM_PHASES - 1) begin
                calm = 1;
                n_windows = WINDOWS_PER_PHASE + CALM_WINDOWS;
            end
            for (int w = 0; w < n_windows; w++) send_window();
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.readings.size() != 0) sb.report("readings never produced");
        if (sb.errors == 0) begin
            $display("ntc_trimmed_mean_temperature regression: pass");
        end else begin
            $display("ntc_trimmed_mean_temperature regression: fail");
        end
        $finish;
    end
endmodule

/* ntc_trimmed_mean_temperature.f */
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_cell.sv
hw/rtl/ntc_window.sv
hw/rtl/ntc_trimmed_mean_temperature.sv
bench/tb_ntc_trimmed_mean_temperature.sv
